### rtl/cbf_pkg.sv
// Shared types and constants of the cubic Bezier flattener.
// Depends on nothing; imported by cbf_chord_test and the top level.
`default_nettype none

package cbf_pkg;

   localparam int MAX_DEPTH_DEFAULT  = 6;
   localparam int COORD_BITS_DEFAULT = 24;

   localparam int OPCODE_BITS = 2;
   localparam logic [OPCODE_BITS-1:0] OP_BEGIN = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_CUBIC = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_END   = 2'd2;

   localparam int TOL_BITS  = 16;
   localparam int TOL2_BITS = 2 * TOL_BITS;
   localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd256;

   // chord parameter t is a Q0.16 fraction
   localparam int FRAC_BITS = 16;

   typedef struct packed {
      logic done;
      logic far;
   } cbf_test_status_type;

endpackage

`default_nettype wire

### rtl/cbf_stack.sv
// Pending-half stack of the flattener: one row per subdivision level.
// Synchronous RAM, one write and one registered read port. Uses no package items.
`default_nettype none

module cbf_stack #(
   parameter int DEPTH = 6,
   parameter int WIDTH = 195,
   parameter int AW    = 3
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/cbf_chord_test.sv
// Flatness test: squared distance from a curve midpoint to the clamped chord,
// compared with the squared tolerance. One shared multiplier, bit-serial divider.
// Depends on cbf_pkg.
`default_nettype none

module cbf_chord_test #(
   parameter int COORD_BITS = cbf_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic signed [COORD_BITS-1:0]       p_x,
   input  wire logic signed [COORD_BITS-1:0]       p_y,
   input  wire logic signed [COORD_BITS-1:0]       q_x,
   input  wire logic signed [COORD_BITS-1:0]       q_y,
   input  wire logic signed [COORD_BITS-1:0]       m_x,
   input  wire logic signed [COORD_BITS-1:0]       m_y,
   input  wire logic        [cbf_pkg::TOL2_BITS-1:0] tol2,
   output cbf_pkg::cbf_test_status_type            status
);
   import cbf_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int D  = CB + 1;
   localparam int MW = (D > FRAC_BITS + 2) ? D : FRAC_BITS + 2;
   localparam int PW = 2 * MW;
   localparam int W  = PW + 1;

   localparam logic [3:0] C_IDLE = 4'd0;
   localparam logic [3:0] C_VV   = 4'd1;
   localparam logic [3:0] C_VV2  = 4'd2;
   localparam logic [3:0] C_VW   = 4'd3;
   localparam logic [3:0] C_VW2  = 4'd4;
   localparam logic [3:0] C_SUM  = 4'd5;
   localparam logic [3:0] C_PICK = 4'd6;
   localparam logic [3:0] C_DIV  = 4'd7;
   localparam logic [3:0] C_TX   = 4'd8;
   localparam logic [3:0] C_TY   = 4'd9;
   localparam logic [3:0] C_EY   = 4'd10;
   localparam logic [3:0] C_SQX  = 4'd11;
   localparam logic [3:0] C_SQY  = 4'd12;
   localparam logic [3:0] C_ACC  = 4'd13;
   localparam logic [3:0] C_CMP  = 4'd14;

   logic [3:0] state_ff, state_in;
   logic signed [MW-1:0] vx_ff, vy_ff, wx_ff, wy_ff, ux_ff, uy_ff, ex_ff, ey_ff;
   logic signed [PW-1:0] prod_ff;
   logic signed [W-1:0]  d_ff, tn_ff, r_ff, dist_ff;
   logic [FRAC_BITS-1:0] t_ff;
   logic [3:0]           cnt_ff;
   logic                 done_ff, far_ff;

   logic signed [MW-1:0] op_a, op_b, t_ext;
   logic signed [W-1:0]  prod_ext, r_shift, r_diff;
   logic signed [PW-1:0] prod_frac;
   logic                 tn_not_pos;

   function automatic logic signed [MW-1:0] ext(input logic signed [CB-1:0] v);
      return {{(MW-CB){v[CB-1]}}, v};
   endfunction

   assign t_ext      = {{(MW-FRAC_BITS){1'b0}}, t_ff};
   assign prod_ext   = {prod_ff[PW-1], prod_ff};
   assign prod_frac  = prod_ff >>> FRAC_BITS;
   assign r_shift    = r_ff <<< 1;
   assign r_diff     = r_shift - d_ff;
   assign tn_not_pos = tn_ff[W-1] || (tn_ff == '0);

   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (state_ff)
         C_VV:  begin op_a = vx_ff; op_b = vx_ff; end
         C_VV2: begin op_a = vy_ff; op_b = vy_ff; end
         C_VW:  begin op_a = vx_ff; op_b = wx_ff; end
         C_VW2: begin op_a = vy_ff; op_b = wy_ff; end
         C_TX:  begin op_a = t_ext; op_b = vx_ff; end
         C_TY:  begin op_a = t_ext; op_b = vy_ff; end
         C_SQX: begin op_a = ex_ff; op_b = ex_ff; end
         C_SQY: begin op_a = ey_ff; op_b = ey_ff; end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         C_IDLE: if (start) state_in = C_VV;
         C_VV:   state_in = C_VV2;
         C_VV2:  state_in = C_VW;
         C_VW:   state_in = C_VW2;
         C_VW2:  state_in = C_SUM;
         C_SUM:  state_in = C_PICK;
         C_PICK: begin
            if (d_ff == '0 || tn_not_pos || tn_ff >= d_ff) state_in = C_SQX;
            else state_in = C_DIV;
         end
         C_DIV:  if (cnt_ff == 4'(FRAC_BITS - 1)) state_in = C_TX;
         C_TX:   state_in = C_TY;
         C_TY:   state_in = C_EY;
         C_EY:   state_in = C_SQX;
         C_SQX:  state_in = C_SQY;
         C_SQY:  state_in = C_ACC;
         C_ACC:  state_in = C_CMP;
         C_CMP:  state_in = C_IDLE;
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
         far_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == C_CMP);
         if (state_ff == C_CMP) begin
            far_ff <= (dist_ff > W'(tol2));
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      unique case (state_ff)
         C_IDLE: begin
            if (start) begin
               vx_ff <= ext(q_x) - ext(p_x);
               vy_ff <= ext(q_y) - ext(p_y);
               wx_ff <= ext(m_x) - ext(p_x);
               wy_ff <= ext(m_y) - ext(p_y);
               ux_ff <= ext(m_x) - ext(q_x);
               uy_ff <= ext(m_y) - ext(q_y);
            end
         end
         C_VV2: d_ff  <= prod_ext;
         C_VW:  d_ff  <= d_ff + prod_ext;
         C_VW2: tn_ff <= prod_ext;
         C_SUM: tn_ff <= tn_ff + prod_ext;
         C_PICK: begin
            // clamp t to 0 or 1 where the projection leaves the chord
            if (d_ff == '0 || tn_not_pos) begin
               ex_ff <= wx_ff;
               ey_ff <= wy_ff;
            end else if (tn_ff >= d_ff) begin
               ex_ff <= ux_ff;
               ey_ff <= uy_ff;
            end else begin
               r_ff   <= tn_ff;
               t_ff   <= '0;
               cnt_ff <= '0;
            end
         end
         C_DIV: begin
            cnt_ff <= cnt_ff + 4'd1;
            if (r_shift >= d_ff) begin
               r_ff <= r_diff;
               t_ff <= {t_ff[FRAC_BITS-2:0], 1'b1};
            end else begin
               r_ff <= r_shift;
               t_ff <= {t_ff[FRAC_BITS-2:0], 1'b0};
            end
         end
         C_TY:  ex_ff   <= prod_frac[MW-1:0] - wx_ff;
         C_EY:  ey_ff   <= prod_frac[MW-1:0] - wy_ff;
         C_SQY: dist_ff <= prod_ext;
         C_ACC: dist_ff <= dist_ff + prod_ext;
         default: begin end
      endcase
   end

   assign status.done = done_ff;
   assign status.far  = far_ff;

   a_div_rem_below: assert property (@(posedge clock) disable iff (reset)
      state_ff == C_DIV |-> r_ff < d_ff)
      else $error("divider remainder not below divisor");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("test done held longer than one cycle");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == C_IDLE)
      else $error("test started while busy");

endmodule

`default_nettype wire

### rtl/cubic_bezier_flattener_top.sv
// Top level of the cubic Bezier flattener: sequencer, midpoint logic, output register.
// Depends on cbf_pkg, cbf_stack and cbf_chord_test.
//
// Path words enter on req_ and polyline vertices leave on rsp_, one word per item
// result. A cubic is split adaptively by de Casteljau midpoints; every flatness test
// runs on a shared multiplier and a one-bit-per-cycle divider. Each piece that is
// flat or at the depth cap emits its end point and, while halves are pending, a pop
// from the stack memory reloads the next one; a cubic takes up to 63 tests with the
// default MAX_DEPTH. Halves waiting for processing sit in a one-row-per-level RAM.
// A new item is taken only once the previous one has issued its last result word.
`default_nettype none

module cubic_bezier_flattener_top #(
   parameter int MAX_DEPTH  = cbf_pkg::MAX_DEPTH_DEFAULT,
   parameter int COORD_BITS = cbf_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [cbf_pkg::OPCODE_BITS-1:0]    req_opcode,
   input  wire logic signed [COORD_BITS-1:0]       req_start_x,
   input  wire logic signed [COORD_BITS-1:0]       req_start_y,
   input  wire logic signed [COORD_BITS-1:0]       req_ctrl1_x,
   input  wire logic signed [COORD_BITS-1:0]       req_ctrl1_y,
   input  wire logic signed [COORD_BITS-1:0]       req_ctrl2_x,
   input  wire logic signed [COORD_BITS-1:0]       req_ctrl2_y,
   input  wire logic signed [COORD_BITS-1:0]       req_end_x,
   input  wire logic signed [COORD_BITS-1:0]       req_end_y,
   input  wire logic                               req_closed,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [COORD_BITS-1:0]            rsp_point_x,
   output logic signed [COORD_BITS-1:0]            rsp_point_y,
   output logic                                    rsp_point_valid,
   output logic                                    rsp_path_end,
   output logic                                    rsp_last,
   input  wire logic                               csr_wr_en,
   input  wire logic [cbf_pkg::TOL_BITS-1:0]       csr_wr_data
);
   import cbf_pkg::*;

   localparam int CB   = COORD_BITS;
   localparam int DW   = $clog2(MAX_DEPTH + 1);
   localparam int AW   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int PTW  = 2 * CB;
   localparam int ROWW = 4 * PTW + DW;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_BEGIN = 3'd1;
   localparam logic [2:0] S_START = 3'd2;
   localparam logic [2:0] S_END   = 3'd3;
   localparam logic [2:0] S_MID   = 3'd4;
   localparam logic [2:0] S_TEST  = 3'd5;
   localparam logic [2:0] S_LEAF  = 3'd6;
   localparam logic [2:0] S_POP   = 3'd7;

   logic [2:0]           state_ff, state_in;
   logic [TOL2_BITS-1:0] tol2_ff;
   logic signed [CB-1:0] path_x_ff, path_y_ff;
   logic signed [CB-1:0] cur_x_ff [4];
   logic signed [CB-1:0] cur_y_ff [4];
   logic signed [CB-1:0] a_x_ff, a_y_ff, ab_x_ff, ab_y_ff, m_x_ff, m_y_ff;
   logic signed [CB-1:0] bc_x_ff, bc_y_ff, cc_x_ff, cc_y_ff;
   logic [DW-1:0]        depth_ff, sp_ff;

   logic                 rsp_valid_ff;
   logic signed [CB-1:0] rsp_x_ff, rsp_y_ff;
   logic                 rsp_pv_ff, rsp_pe_ff, rsp_last_ff;

   logic signed [CB-1:0] a_x, a_y, b_x, b_y, c_x, c_y, ab_x, ab_y, bc_x, bc_y, m_x, m_y;
   logic                 slot_free, accept, at_cap, push, pop;
   logic                 emit_go, emit_pv, emit_pe, emit_last;
   logic signed [CB-1:0] emit_x, emit_y;
   logic [ROWW-1:0]      wr_row, rd_row;
   logic [DW-1:0]        sp_dec;
   cbf_test_status_type  test;

   function automatic logic signed [CB-1:0] half_mid(input logic signed [CB-1:0] u,
                                                     input logic signed [CB-1:0] v);
      logic signed [CB:0] s;
      s = {u[CB-1], u} + {v[CB-1], v};
      return s[CB:1];
   endfunction

   assign a_x  = half_mid(cur_x_ff[0], cur_x_ff[1]);
   assign a_y  = half_mid(cur_y_ff[0], cur_y_ff[1]);
   assign b_x  = half_mid(cur_x_ff[1], cur_x_ff[2]);
   assign b_y  = half_mid(cur_y_ff[1], cur_y_ff[2]);
   assign c_x  = half_mid(cur_x_ff[2], cur_x_ff[3]);
   assign c_y  = half_mid(cur_y_ff[2], cur_y_ff[3]);
   assign ab_x = half_mid(a_x, b_x);
   assign ab_y = half_mid(a_y, b_y);
   assign bc_x = half_mid(b_x, c_x);
   assign bc_y = half_mid(b_y, c_y);
   assign m_x  = half_mid(ab_x, bc_x);
   assign m_y  = half_mid(ab_y, bc_y);

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign at_cap    = (depth_ff == DW'(MAX_DEPTH));
   assign push      = (state_ff == S_TEST) && test.done && test.far
                      && (sp_ff < DW'(MAX_DEPTH));
   assign pop       = (state_ff == S_LEAF) && slot_free && (sp_ff != '0);
   assign sp_dec    = sp_ff - DW'(1);

   assign wr_row = {m_x_ff, m_y_ff, bc_x_ff, bc_y_ff, cc_x_ff, cc_y_ff,
                    cur_x_ff[3], cur_y_ff[3], depth_ff + DW'(1)};

   cbf_stack #(
      .DEPTH (MAX_DEPTH),
      .WIDTH (ROWW),
      .AW    (AW)
   ) u_stack (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (sp_ff[AW-1:0]),
      .wr_data (wr_row),
      .rd_en   (pop),
      .rd_addr (sp_dec[AW-1:0]),
      .rd_data (rd_row)
   );

   cbf_chord_test #(
      .COORD_BITS (CB)
   ) u_test (
      .clock  (clock),
      .reset  (reset),
      .start  ((state_ff == S_MID) && !at_cap),
      .p_x    (cur_x_ff[0]),
      .p_y    (cur_y_ff[0]),
      .q_x    (cur_x_ff[3]),
      .q_y    (cur_y_ff[3]),
      .m_x    (m_x),
      .m_y    (m_y),
      .tol2   (tol2_ff),
      .status (test)
   );

   always_comb begin
      state_in  = state_ff;
      emit_go   = 1'b0;
      emit_x    = '0;
      emit_y    = '0;
      emit_pv   = 1'b0;
      emit_pe   = 1'b0;
      emit_last = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               priority if (req_opcode == OP_BEGIN) state_in = S_BEGIN;
               else if (req_opcode == OP_CUBIC) state_in = S_MID;
               else if (req_opcode == OP_END) state_in = req_closed ? S_START : S_END;
               else state_in = S_IDLE;
            end
         end
         S_BEGIN, S_START: begin
            if (slot_free) begin
               emit_go   = 1'b1;
               emit_x    = path_x_ff;
               emit_y    = path_y_ff;
               emit_pv   = 1'b1;
               emit_last = (state_ff == S_BEGIN);
               state_in  = (state_ff == S_BEGIN) ? S_IDLE : S_END;
            end
         end
         S_END: begin
            if (slot_free) begin
               emit_go   = 1'b1;
               emit_pe   = 1'b1;
               emit_last = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_MID:  state_in = at_cap ? S_LEAF : S_TEST;
         S_TEST: if (test.done) state_in = push ? S_MID : S_LEAF;
         S_LEAF: begin
            if (slot_free) begin
               emit_go   = 1'b1;
               emit_x    = cur_x_ff[3];
               emit_y    = cur_y_ff[3];
               emit_pv   = 1'b1;
               emit_last = (sp_ff == '0);
               state_in  = (sp_ff == '0) ? S_IDLE : S_POP;
            end
         end
         S_POP:  state_in = S_MID;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tol2_ff      <= TOL2_BITS'(TOL_RESET) * TOL2_BITS'(TOL_RESET);
         path_x_ff    <= '0;
         path_y_ff    <= '0;
         depth_ff     <= '0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            tol2_ff <= TOL2_BITS'(csr_wr_data) * TOL2_BITS'(csr_wr_data);
         end
         if (accept && req_opcode == OP_BEGIN) begin
            path_x_ff <= req_start_x;
            path_y_ff <= req_start_y;
         end
         if (accept && req_opcode == OP_CUBIC) begin
            depth_ff <= '0;
            sp_ff    <= '0;
         end
         if (push) begin
            depth_ff <= depth_ff + DW'(1);
            sp_ff    <= sp_ff + DW'(1);
         end
         if (pop) begin
            sp_ff <= sp_dec;
         end
         if (state_ff == S_POP) begin
            depth_ff <= rd_row[DW-1:0];
         end
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_x_ff    <= emit_x;
         rsp_y_ff    <= emit_y;
         rsp_pv_ff   <= emit_pv;
         rsp_pe_ff   <= emit_pe;
         rsp_last_ff <= emit_last;
      end
      if (accept && req_opcode == OP_CUBIC) begin
         cur_x_ff[0] <= req_start_x;
         cur_y_ff[0] <= req_start_y;
         cur_x_ff[1] <= req_ctrl1_x;
         cur_y_ff[1] <= req_ctrl1_y;
         cur_x_ff[2] <= req_ctrl2_x;
         cur_y_ff[2] <= req_ctrl2_y;
         cur_x_ff[3] <= req_end_x;
         cur_y_ff[3] <= req_end_y;
      end
      if (state_ff == S_MID) begin
         a_x_ff  <= a_x;
         a_y_ff  <= a_y;
         ab_x_ff <= ab_x;
         ab_y_ff <= ab_y;
         m_x_ff  <= m_x;
         m_y_ff  <= m_y;
         bc_x_ff <= bc_x;
         bc_y_ff <= bc_y;
         cc_x_ff <= c_x;
         cc_y_ff <= c_y;
      end
      // keep the first half in place, the second one went to the stack
      if (push) begin
         cur_x_ff[1] <= a_x_ff;
         cur_y_ff[1] <= a_y_ff;
         cur_x_ff[2] <= ab_x_ff;
         cur_y_ff[2] <= ab_y_ff;
         cur_x_ff[3] <= m_x_ff;
         cur_y_ff[3] <= m_y_ff;
      end
      if (state_ff == S_POP) begin
         for (int k = 0; k < 4; k++) begin
            cur_x_ff[k] <= rd_row[DW + (3 - k) * PTW + CB +: CB];
            cur_y_ff[k] <= rd_row[DW + (3 - k) * PTW +: CB];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_x     = rsp_x_ff;
   assign rsp_point_y     = rsp_y_ff;
   assign rsp_point_valid = rsp_pv_ff;
   assign rsp_path_end    = rsp_pe_ff;
   assign rsp_last        = rsp_last_ff;

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= DW'(MAX_DEPTH) && depth_ff <= DW'(MAX_DEPTH))
      else $error("stack pointer or depth beyond the cap");
   a_done_in_test: assert property (@(posedge clock) disable iff (reset)
      test.done |-> state_ff == S_TEST)
      else $error("flatness result arrived outside the test state");
   a_pop_follows: assert property (@(posedge clock) disable iff (reset)
      pop |=> state_ff == S_POP && !rsp_valid_ff == 1'b0)
      else $error("pop not followed by reload with a word in the output");

endmodule

`default_nettype wire
